// ===== design/bcc_pkg.sv =====
// Package for the button click classifier: state and configuration types,
// click codes and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int KIND_W = 2;

    // Click codes reported on the result channel.
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_LONG     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_WINDOW   = 2'd2;

    // Configuration reset values in milliseconds.
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RESET     = 16'd1000;
    localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd300;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_delay;
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] double_click_window;
    } bcc_cfg_t;

    typedef struct packed {
        logic              pressed_flag;
        logic              previous_raw;
        logic              awaiting_second;
        logic              single_pending;
        logic [TIME_W-1:0] level_change_time;
        logic [TIME_W-1:0] press_begin_time;
        logic [TIME_W-1:0] release_time;
    } bcc_state_t;

endpackage

// ===== design/bcc_cfg_regs.sv =====
// Configuration register file of the button click classifier.
// Depends on bcc_pkg for the register indexes and the bcc_cfg_t type.
`timescale 1ns / 1ps

module bcc_cfg_regs
    import bcc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output bcc_cfg_t         cfg
);

    bcc_cfg_t cfg_reg;
    bcc_cfg_t cfg_next;

    // A write of zero leaves the register unchanged.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we && (cfg_wdata != '0)) begin
            case (cfg_index)
                CFG_IDX_DEBOUNCE: cfg_next.debounce_delay      = cfg_wdata;
                CFG_IDX_LONG:     cfg_next.long_press_time     = cfg_wdata;
                CFG_IDX_WINDOW:   cfg_next.double_click_window = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_delay      <= DEBOUNCE_RESET;
            cfg_reg.long_press_time     <= LONG_RESET;
            cfg_reg.double_click_window <= WINDOW_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bcc_classify.sv =====
// Next-state and click decision logic for one poll of the classifier.
// Depends on bcc_pkg for the state and configuration types and the codes.
`timescale 1ns / 1ps

module bcc_classify
    import bcc_pkg::*;
(
    input  bcc_state_t        state,
    input  bcc_cfg_t          cfg,
    input  logic              raw_level,
    input  logic [TIME_W-1:0] now_ms,
    output bcc_state_t        state_next,
    output logic [KIND_W-1:0] click_kind
);

    logic [TIME_W-1:0] stable_ms;
    logic [TIME_W-1:0] press_ms;
    logic [TIME_W-1:0] since_release_ms;
    logic              decided;

    always_comb begin
        state_next       = state;
        click_kind       = KIND_NONE;
        decided          = 1'b0;
        stable_ms        = '0;
        press_ms         = now_ms - state.press_begin_time;
        since_release_ms = '0;

        // A level change restarts the debounce timer.
        if (raw_level != state.previous_raw) begin
            state_next.level_change_time = now_ms;
            state_next.previous_raw      = raw_level;
        end
        stable_ms = now_ms - state_next.level_change_time;

        if (stable_ms > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_delay}) begin
            if (raw_level && !state.pressed_flag) begin
                state_next.pressed_flag     = 1'b1;
                state_next.press_begin_time = now_ms;
            end
            if (!raw_level && state.pressed_flag) begin
                state_next.pressed_flag = 1'b0;
                if (press_ms >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time}) begin
                    state_next.awaiting_second = 1'b0;
                    state_next.single_pending  = 1'b0;
                    click_kind                 = KIND_LONG;
                    decided                    = 1'b1;
                end else if (state.awaiting_second) begin
                    state_next.awaiting_second = 1'b0;
                    state_next.single_pending  = 1'b0;
                    click_kind                 = KIND_DOUBLE;
                    decided                    = 1'b1;
                end else begin
                    state_next.awaiting_second = 1'b1;
                    state_next.single_pending  = 1'b1;
                    state_next.release_time    = now_ms;
                end
            end
        end

        // The window check sees a release from this same poll as zero elapsed time.
        since_release_ms = now_ms - state_next.release_time;
        if (!decided && state_next.single_pending &&
            (since_release_ms > {{(TIME_W-CFG_W){1'b0}}, cfg.double_click_window})) begin
            state_next.single_pending  = 1'b0;
            state_next.awaiting_second = 1'b0;
            click_kind                 = KIND_SHORT;
        end
    end

endmodule

// ===== design/button_click_classifier.sv =====
// Top level of the button click classifier: poll input register, click
// decision, result register. Depends on bcc_pkg, bcc_cfg_regs, bcc_classify.
`timescale 1ns / 1ps

// Usage:
// Each request on the s_ channel is one poll of the button: the raw pin level
// and a free-running millisecond timestamp. Every poll produces exactly one
// request on the m_ channel carrying m_click_kind (none, short, long or
// double click). Both channels use valid/ready handshakes.
// A poll is captured in an input register, classified by one pass of
// combinational logic that also updates the debounce and click state, and the
// result lands in an output register once that register is empty or being
// drained. Throughput is one poll per cycle while the receiver does not
// stall, set by that single pass.
// While the output register is held by a stalled receiver, one more poll can
// wait in the input register; s_ready drops only when both are full, so no
// poll is lost and the state advances only when a result is committed.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; writes of
// zero and writes to an unused index are ignored. Write it only
// while no poll is in flight.
// Synchronous active-low reset empties both registers, restores the register
// defaults (50, 1000 and 300 ms) and clears all click state and timestamps.
module button_click_classifier
    import bcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_raw_level,
    input  logic [TIME_W-1:0] s_now_ms,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_click_kind,

    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    bcc_cfg_t          cfg;

    // Input register holding the poll under classification.
    logic              in_valid_reg;
    logic              in_raw_reg;
    logic [TIME_W-1:0] in_now_reg;

    // Output register holding the result for the receiver.
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;

    // Click and debounce state, updated once per committed poll.
    bcc_state_t        state_reg;
    bcc_state_t        state_next;
    logic [KIND_W-1:0] kind_next;

    logic              advance;
    logic              s_accept;

    bcc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcc_classify u_classify (
        .state      (state_reg),
        .cfg        (cfg),
        .raw_level  (in_raw_reg),
        .now_ms     (in_now_reg),
        .state_next (state_next),
        .click_kind (kind_next)
    );

    // The poll in the input register moves on whenever the output register
    // is empty or is being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_raw_reg <= s_raw_level;
            in_now_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_kind_reg <= kind_next;
        end
    end

    // The state must reset to zero, timestamps included, since the elapsed
    // times after reset are measured from time zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_click_kind = out_kind_reg;

    // The waiting and pending flags are always set and cleared together.
    a_flags_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.awaiting_second == state_reg.single_pending)
        else $error("awaiting_second and single_pending disagree");

    // A long or double click is only reported on a debounced release.
    a_click_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (kind_next == KIND_LONG || kind_next == KIND_DOUBLE))
        |=> (!state_reg.pressed_flag && !state_reg.single_pending))
        else $error("long or double click without a release");

    // A poll waiting behind a stalled result is neither lost nor altered.
    a_poll_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_now_reg)
        && $stable(in_raw_reg)))
        else $error("held poll changed");

    // The click state changes only when a poll is committed.
    a_state_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a committed poll");

endmodule

// ===== tb/tb_button_click_classifier.sv =====
// Self-checking testbench for button_click_classifier: debounce, long press,
// double click and window expiry are checked poll by poll. Depends on bcc_pkg.
`timescale 1ns / 1ps

module tb_button_click_classifier;
    import bcc_pkg::*;

    // The block ignores writes to the fourth register slot.
    localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_raw_level;
    logic [TIME_W-1:0] s_now_ms;
    logic              m_valid;
    logic              m_ready;
    logic [KIND_W-1:0] m_click_kind;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;

    button_click_classifier dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_level  (s_raw_level),
        .s_now_ms     (s_now_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_click_kind (m_click_kind),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // Our own copy of the configuration and of the click state. Both are
    // advanced at the rising edge, in step with what the block accepts.
    bcc_cfg_t          cfg_regs;
    bcc_state_t        btn_state;
    logic [KIND_W-1:0] expected_kinds[$];

    logic [TIME_W-1:0] ms_now;
    int                polls_accepted;
    int                errors;
    int                reg_writes;
    int                kind_count[4];
    bit                gaps_on;
    bit                stalls_on;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Works out the click kind that one poll produces and advances the
    // state. Every elapsed time is a wrapping 32-bit difference, so a
    // timestamp that goes backwards reads as a very long interval.
    function automatic logic [KIND_W-1:0] classify_poll(input logic lvl,
                                                        input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] press_len;
        logic [TIME_W-1:0] since_release;
        if (lvl != btn_state.previous_raw) begin
            btn_state.level_change_time = t;
            btn_state.previous_raw = lvl;
        end
        held = t - btn_state.level_change_time;
        if (held > TIME_W'(cfg_regs.debounce_delay)) begin
            if (lvl && !btn_state.pressed_flag) begin
                btn_state.pressed_flag = 1'b1;
                btn_state.press_begin_time = t;
            end
            if (!lvl && btn_state.pressed_flag) begin
                btn_state.pressed_flag = 1'b0;
                press_len = t - btn_state.press_begin_time;
                if (press_len >= TIME_W'(cfg_regs.long_press_time)) begin
                    btn_state.awaiting_second = 1'b0;
                    btn_state.single_pending = 1'b0;
                    return KIND_LONG;
                end
                if (btn_state.awaiting_second) begin
                    btn_state.awaiting_second = 1'b0;
                    btn_state.single_pending = 1'b0;
                    return KIND_DOUBLE;
                end
                // First short release: open the window. The check below sees
                // zero elapsed time, so it cannot fire on this same poll.
                btn_state.awaiting_second = 1'b1;
                btn_state.single_pending = 1'b1;
                btn_state.release_time = t;
            end
        end
        since_release = t - btn_state.release_time;
        if (btn_state.single_pending &&
            since_release > TIME_W'(cfg_regs.double_click_window)) begin
            btn_state.single_pending = 1'b0;
            btn_state.awaiting_second = 1'b0;
            return KIND_SHORT;
        end
        return KIND_NONE;
    endfunction

    // Everything is sampled here at the rising edge. The inputs were driven
    // at the falling edge, so the values seen are settled ones.
    always @(posedge aclk) begin
        logic [KIND_W-1:0] want;
        if (!aresetn) begin
            cfg_regs.debounce_delay = DEBOUNCE_RESET;
            cfg_regs.long_press_time = LONG_RESET;
            cfg_regs.double_click_window = WINDOW_RESET;
            btn_state = '0;
            expected_kinds.delete();
        end else begin
            // A zero value or the unused index leaves the registers alone.
            if (cfg_we && cfg_wdata != '0) begin
                case (cfg_index)
                    CFG_IDX_DEBOUNCE: cfg_regs.debounce_delay = cfg_wdata;
                    CFG_IDX_LONG:     cfg_regs.long_press_time = cfg_wdata;
                    CFG_IDX_WINDOW:   cfg_regs.double_click_window = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_kinds.push_back(classify_poll(s_raw_level, s_now_ms));
                polls_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_kinds.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: click_kind %0d arrived with no poll outstanding",
                                 m_click_kind);
                end else begin
                    want = expected_kinds.pop_front();
                    if (m_click_kind !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: click_kind expected %0d, got %0d at %0t",
                                     want, m_click_kind, $realtime);
                    end else begin
                        kind_count[want]++;
                    end
                end
            end
        end
    end

    // The receiver holds m_ready low in bursts of random length while stalls_on is set.
    initial begin
        int stall_left;
        m_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Sends one poll request, time advanced by step (which may wrap or go
    // backwards), and returns at the falling edge after it was taken. Valid is
    // left high so that back-to-back polls follow without a gap.
    task automatic poll(input logic lvl, input logic [TIME_W-1:0] step);
        int target;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        ms_now = ms_now + step;
        target = polls_accepted + 1;
        s_valid = 1'b1;
        s_raw_level = lvl;
        s_now_ms = ms_now;
        while (polls_accepted < target) @(negedge aclk);
    endtask

    // Stops sending and waits until every poll has its result back.
    task automatic drain_results();
        s_valid = 1'b0;
        while (expected_kinds.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        reg_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Moves the pin to lvl, sometimes with contact chatter: each bounce comes
    // within the debounce delay of the last change, so none is accepted.
    task automatic bounce_to(input logic lvl, input int first_step);
        int deb;
        deb = int'(cfg_regs.debounce_delay);
        poll(lvl, first_step);
        repeat ($urandom_range(0, 3)) begin
            poll(!lvl, $urandom_range(0, deb));
            poll(lvl, $urandom_range(0, deb));
        end
    endtask

    // Holds lvl until the debounce accepts it: sometimes a poll lands right on
    // the delay (not yet stable enough) and the next one just past it.
    task automatic settle(input logic lvl);
        int deb;
        deb = int'(cfg_regs.debounce_delay);
        case ($urandom_range(0, 2))
            0: begin
                poll(lvl, deb);
                poll(lvl, 1);
            end
            1: poll(lvl, deb + 1);
            default: poll(lvl, deb + 1 + $urandom_range(0, deb));
        endcase
    endtask

    // One press and release, with the press length placed around the long
    // press limit or well below it, then some way of spending the window.
    task automatic one_click();
        int deb;
        int lp;
        int win;
        int hold;
        int lead;
        deb = int'(cfg_regs.debounce_delay);
        lp = int'(cfg_regs.long_press_time);
        win = int'(cfg_regs.double_click_window);
        bounce_to(1'b1, $urandom_range(1, 40));
        settle(1'b1);
        case ($urandom_range(0, 5))
            0: hold = lp - 1;
            1: hold = lp;
            2: hold = lp + $urandom_range(1, 50);
            default: hold = $urandom_range(1, (lp < 200) ? lp : 200);
        endcase
        lead = hold - deb - 1;
        if (lead < 1)
            lead = 1;
        bounce_to(1'b0, lead);
        settle(1'b0);
        case ($urandom_range(0, 3))
            0: begin
                // Right at the window limit, then one past it.
                poll(1'b0, win);
                poll(1'b0, 1);
            end
            1: repeat ($urandom_range(1, 4)) poll(1'b0, $urandom_range(0, win / 2 + 1));
            2: ;  // the next press follows at once and may make a double click
            default: poll(1'b0, win + $urandom_range(1, 2000));
        endcase
    endtask

    task automatic run_clicks(input int n);
        repeat (n) one_click();
    endtask

    // Random levels with random times: jumps anywhere on the time line,
    // steps backwards and ordinary forward steps.
    task automatic noise_polls(input int n);
        int deb;
        deb = int'(cfg_regs.debounce_delay);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: begin
                    ms_now = $urandom();
                    poll(1'($urandom_range(0, 1)), 0);
                end
                1: poll(1'($urandom_range(0, 1)), -$urandom_range(1, 500));
                default: poll(1'($urandom_range(0, 1)), $urandom_range(0, 2 * deb + 2));
            endcase
        end
    endtask

    function automatic int pick_setting(input int lo, input int hi);
        case ($urandom_range(0, 15))
            0: return 1;
            1: return 65535;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Reset values: a short click expiring exactly past the window, a press of
    // exactly the long press time, one a millisecond short of it followed by
    // a double click, and a press preceded by chatter.
    task automatic test_default_clicks();
        poll(1'b1, 10);
        poll(1'b1, 51);
        poll(1'b0, 100);
        poll(1'b0, 50);
        poll(1'b0, 1);
        poll(1'b0, 300);
        poll(1'b0, 1);
        poll(1'b1, 5);
        poll(1'b1, 51);
        poll(1'b0, 949);
        poll(1'b0, 51);
        poll(1'b1, 5);
        poll(1'b1, 51);
        poll(1'b0, 948);
        poll(1'b0, 51);
        poll(1'b1, 10);
        poll(1'b1, 51);
        poll(1'b0, 20);
        poll(1'b0, 51);
        poll(1'b1, 5);
        poll(1'b0, 20);
        poll(1'b1, 20);
        poll(1'b1, 51);
    endtask

    // Zero writes and the unused index must change nothing; then the
    // smallest and largest settings for all three registers.
    task automatic test_register_writes();
        drain_results();
        write_reg(CFG_IDX_DEBOUNCE, '0);
        write_reg(CFG_IDX_LONG, '0);
        write_reg(CFG_IDX_WINDOW, '0);
        write_reg(CFG_IDX_UNUSED, 16'hFFFF);
        run_clicks(4);
        drain_results();
        write_reg(CFG_IDX_DEBOUNCE, 16'd1);
        write_reg(CFG_IDX_LONG, 16'd1);
        write_reg(CFG_IDX_WINDOW, 16'd1);
        run_clicks(8);
        drain_results();
        write_reg(CFG_IDX_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_IDX_LONG, 16'hFFFF);
        write_reg(CFG_IDX_WINDOW, 16'hFFFF);
        run_clicks(5);
    endtask

    // Clicks that straddle the wrap of the millisecond counter.
    task automatic test_time_wrap();
        drain_results();
        write_reg(CFG_IDX_DEBOUNCE, 16'd20);
        write_reg(CFG_IDX_LONG, 16'd400);
        write_reg(CFG_IDX_WINDOW, 16'd150);
        ms_now = 32'hFFFF_FFFF - $urandom_range(0, 600);
        run_clicks(12);
        noise_polls(10);
    endtask

    // Phases of random settings, each drained before the next write. Most
    // polls form proper clicks; some phases add raw noise.
    task automatic test_random_phases();
        while (polls_accepted < 1450) begin
            drain_results();
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            write_reg(CFG_IDX_DEBOUNCE, CFG_W'(pick_setting(2, 60)));
            write_reg(CFG_IDX_LONG, CFG_W'(pick_setting(20, 1500)));
            write_reg(CFG_IDX_WINDOW, CFG_W'(pick_setting(40, 600)));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_UNUSED, CFG_W'($urandom()));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_WINDOW, '0);
            run_clicks($urandom_range(8, 20));
            if ($urandom_range(0, 2) == 0)
                noise_polls($urandom_range(5, 20));
        end
    endtask

    // Closing stretch at full rate: no gaps from the sender, no stalls from
    // the receiver.
    task automatic test_back_to_back();
        drain_results();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        write_reg(CFG_IDX_DEBOUNCE, 16'd8);
        write_reg(CFG_IDX_LONG, 16'd250);
        write_reg(CFG_IDX_WINDOW, 16'd120);
        while (polls_accepted < 1680) run_clicks(1);
        noise_polls(20);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_raw_level = 1'b0;
        s_now_ms = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        ms_now = '0;
        polls_accepted = 0;
        errors = 0;
        reg_writes = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        foreach (kind_count[k])
            kind_count[k] = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Every test after the first starts by draining, so the sender pauses
        // until all results are back several times over the run.
        test_default_clicks();
        test_register_writes();
        test_time_wrap();
        test_random_phases();
        test_back_to_back();
        drain_results();

        $display("Checked %0d polls and %0d register writes:",
                 polls_accepted, reg_writes);
        $display("  %0d none, %0d short, %0d long, %0d double.",
                 kind_count[KIND_NONE], kind_count[KIND_SHORT],
                 kind_count[KIND_LONG], kind_count[KIND_DOUBLE]);
        $display("Stimulus had chatter, debounce, long press and window limits,");
        $display("  ignored writes and time wrap.");
        if (errors == 0) begin
            $display("button_click_classifier regression: pass");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("button_click_classifier regression: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #6_000_000;
        $display("TIMEOUT: results still outstanding: %0d", expected_kinds.size());
        $display("button_click_classifier regression: fail");
        $finish;
    end

endmodule
